// File: sv/tcw_pkg.sv
// Shared constants, codes and types of the text console writer.
package tcw_pkg;

  // Screen geometry
  localparam int unsigned COLUMNS    = 80;
  localparam int unsigned ROWS       = 25;
  localparam int unsigned CELL_COUNT = ROWS * COLUMNS;
  localparam int unsigned ADDR_W     = $clog2(CELL_COUNT);

  // Field widths
  localparam int unsigned MODE_W = 2;
  localparam int unsigned CHAR_W = 8;
  localparam int unsigned ATTR_W = 8;
  localparam int unsigned CELL_W = ATTR_W + CHAR_W;
  localparam int unsigned ROW_W  = 5;
  localparam int unsigned COL_W  = 7;
  localparam int unsigned IDX_W  = 11;

  // Stream word widths, padded to whole bytes
  localparam int unsigned IN_BITS     = CHAR_W + ROW_W + COL_W;
  localparam int unsigned IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_BITS    = CELL_W + ROW_W + COL_W + IDX_W;
  localparam int unsigned OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

  // Character codes
  localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
  localparam logic [ATTR_W-1:0] ATTR_RESET = 8'h07;

  // Tab stops every four columns: low bits of the column
  localparam int unsigned TAB_BITS = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_PUT   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    ST_INIT,    // clearing pass after reset
    ST_IDLE,
    ST_EXEC,    // decode the latched word
    ST_PUT,     // write one cell (tab loops here)
    ST_READ,    // cell read data returns
    ST_CLEAR,   // blank sweep for the clear command
    ST_SCROLL,  // row copy sweep
    ST_BLANK,   // fill last row after scroll
    ST_DONE     // hand result to the output register
  } state_e;

  function automatic logic [CELL_W-1:0] make_cell(input logic [ATTR_W-1:0] attr,
                                                  input logic [CHAR_W-1:0] ch);
    return {attr, ch};
  endfunction

endpackage

// File: sv/tcw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module tcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/text_console_writer.sv
// Text console writer top level: sequencer, cursor, screen store and stream ports.
//
// Usage: a command word enters on the s_axis channel (tuser = mode, tdata =
// character, read row, read column). Mode 0 puts a character (newline, return,
// tab, printable), mode 1 reads one cell, mode 2 clears the screen and homes
// the cursor. Every accepted word gives exactly one result word on m_axis:
// read cell, cursor row, cursor column and linear cursor index.
// cfg_we_i writes the attribute byte used for new cells; write it while idle.
// Path, accept to result: a zero byte, return, plain newline, unused mode or
// off-screen read goes from decode straight to done; a printable byte or read
// passes the put or read state first, and a tab loops in put once per space.
// A newline or wrap on the last row scrolls: one row-copy sweep through the
// single RAM port pair, then a fill of the last row. Clear sweeps all CELL_COUNT
// cells, one per cycle. The sweep counter and its adder are the one shared unit;
// the RAM's write port sets the pace.
// One word is in work at a time; s_axis_tready is high only while idle.
// Reset: the cursor homes, the attribute becomes 7, and a clearing pass over all
// CELL_COUNT cells (2000 at 80x25) blanks the store before the first word.
// Stall: a finished result sits in the output register; a new word may be
// taken while it waits, but the next result holds until the receiver takes it.
module text_console_writer (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [7:0] char_code, [12:8] read_row, [19:13] read_col, rest zero
  input  logic [tcw_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  // [1:0] mode
  input  logic [tcw_pkg::MODE_W-1:0]       s_axis_tuser,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [15:0] read_cell, [20:16] cursor_row, [27:21] cursor_col,
  // [38:28] cursor_index, rest zero
  output logic [tcw_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input  logic                             cfg_we_i,
  input  logic [tcw_pkg::ATTR_W-1:0]       cfg_wdata_i
);
  import tcw_pkg::*;

  localparam logic [ADDR_W-1:0] COLS_A     = ADDR_W'(COLUMNS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELL_COUNT - 1);
  localparam logic [ADDR_W-1:0] SCROLL_END = ADDR_W'(CELL_COUNT - COLUMNS);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [ROW_W-1:0]  ROWS_R     = ROW_W'(ROWS);
  localparam logic [COL_W-1:0]  COLS_C     = COL_W'(COLUMNS);

  // Sequencer state
  state_e             state_q, state_d;
  state_e             after_q, after_d;   // where a scroll returns to
  logic [ADDR_W-1:0]  cnt_q, cnt_d;       // shared sweep counter

  // Cursor and attribute
  logic [ROW_W-1:0]   row_q, row_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [ATTR_W-1:0]  attr_q;

  // Latched command word
  logic [MODE_W-1:0]  mode_q;
  logic [CHAR_W-1:0]  char_q;
  logic [ROW_W-1:0]   rrow_q;
  logic [COL_W-1:0]   rcol_q;
  logic [CELL_W-1:0]  cell_q, cell_d;

  // Output register
  logic                    out_valid_q;
  logic [OUT_DATA_W-1:0]   out_data_q;
  logic                    load_out;

  // RAM port
  logic               ram_we, ram_re;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr;
  logic [CELL_W-1:0]  ram_wdata, ram_rdata;

  // Decode helpers
  logic [ADDR_W-1:0]  cur_addr, rd_addr;
  logic [COL_W-1:0]   col_inc;
  logic               s_accept, line_full, on_last_row, rd_in_range, tab_end;

  assign s_accept    = s_axis_tvalid && s_axis_tready;
  assign cur_addr    = ADDR_W'(row_q) * COLS_A + ADDR_W'(col_q);
  assign rd_addr     = ADDR_W'(rrow_q) * COLS_A + ADDR_W'(rcol_q);
  assign col_inc     = col_q + COL_W'(1);
  assign line_full   = (col_q >= COLS_C);
  assign on_last_row = (row_q >= LAST_ROW);
  assign rd_in_range = (rrow_q < ROWS_R) && (rcol_q < COLS_C);
  // tab stops at the next multiple of four or the row end
  assign tab_end     = (col_inc[TAB_BITS-1:0] == '0) || (col_inc == COLS_C);

  tcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_INIT: begin
        if (cnt_q == LAST_CELL) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (s_accept) state_d = ST_EXEC;
      end
      ST_EXEC: begin
        unique case (mode_q)
          MODE_PUT: begin
            unique case (char_q)
              CH_NUL: state_d = ST_DONE;
              CH_CR:  state_d = ST_DONE;
              CH_LF:  state_d = on_last_row ? ST_SCROLL : ST_DONE;
              default: begin
                // wrap first when the line is full
                if (line_full && on_last_row) state_d = ST_SCROLL;
                else                          state_d = ST_PUT;
              end
            endcase
          end
          MODE_READ:  state_d = rd_in_range ? ST_READ : ST_DONE;
          MODE_CLEAR: state_d = ST_CLEAR;
          default:    state_d = ST_DONE;
        endcase
      end
      ST_PUT: begin
        if (char_q != CH_TAB || tab_end) state_d = ST_DONE;
      end
      ST_READ:   state_d = ST_DONE;
      ST_CLEAR: begin
        if (cnt_q == LAST_CELL) state_d = ST_DONE;
      end
      ST_SCROLL: begin
        if (cnt_q == SCROLL_END) state_d = ST_BLANK;
      end
      ST_BLANK: begin
        if (cnt_q == LAST_CELL) state_d = after_q;
      end
      ST_DONE: begin
        if (load_out) state_d = ST_IDLE;
      end
      default:   state_d = ST_INIT;
    endcase
  end

  // Datapath and RAM control
  always_comb begin
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = BLANK_CELL;
    ram_raddr = cnt_q + COLS_A;
    row_d     = row_q;
    col_d     = col_q;
    cnt_d     = cnt_q;
    after_d   = after_q;
    cell_d    = cell_q;
    load_out  = 1'b0;
    unique case (state_q)
      ST_INIT, ST_CLEAR: begin
        ram_we = 1'b1;
        cnt_d  = (cnt_q == LAST_CELL) ? '0 : cnt_q + ADDR_W'(1);
      end
      ST_EXEC: begin
        cell_d = '0;
        unique case (mode_q)
          MODE_PUT: begin
            unique case (char_q)
              CH_NUL: ;
              CH_CR:  col_d = '0;
              CH_LF: begin
                col_d   = '0;
                cnt_d   = '0;
                after_d = ST_DONE;
                if (!on_last_row) row_d = row_q + ROW_W'(1);
              end
              default: begin
                if (line_full) begin
                  col_d   = '0;
                  cnt_d   = '0;
                  after_d = ST_PUT;
                  if (!on_last_row) row_d = row_q + ROW_W'(1);
                end
              end
            endcase
          end
          MODE_READ: begin
            ram_re    = rd_in_range;
            ram_raddr = rd_addr;
          end
          MODE_CLEAR: begin
            row_d = '0;
            col_d = '0;
            cnt_d = '0;
          end
          default: ;
        endcase
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = cur_addr;
        ram_wdata = make_cell(attr_q, (char_q == CH_TAB) ? CH_SPACE : char_q);
        col_d     = col_inc;
      end
      ST_READ: cell_d = ram_rdata;
      ST_SCROLL: begin
        // read row below, write the word fetched last cycle one row up
        ram_re    = (cnt_q != SCROLL_END);
        ram_we    = (cnt_q != '0);
        ram_waddr = cnt_q - ADDR_W'(1);
        ram_wdata = ram_rdata;
        if (cnt_q != SCROLL_END) cnt_d = cnt_q + ADDR_W'(1);
      end
      ST_BLANK: begin
        ram_we    = 1'b1;
        ram_wdata = make_cell(attr_q, CH_SPACE);
        cnt_d     = cnt_q + ADDR_W'(1);
      end
      ST_DONE: load_out = !out_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      after_q     <= ST_DONE;
      cnt_q       <= '0;
      row_q       <= '0;
      col_q       <= '0;
      attr_q      <= ATTR_RESET;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      after_q <= after_d;
      cnt_q   <= cnt_d;
      row_q   <= row_d;
      col_q   <= col_d;
      if (cfg_we_i) attr_q <= cfg_wdata_i;
      if (load_out)           out_valid_q <= 1'b1;
      else if (m_axis_tready) out_valid_q <= 1'b0;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    cell_q <= cell_d;
    if (s_accept) begin
      mode_q <= s_axis_tuser;
      char_q <= s_axis_tdata[7:0];
      rrow_q <= s_axis_tdata[12:8];
      rcol_q <= s_axis_tdata[19:13];
    end
    if (load_out) begin
      out_data_q <= OUT_DATA_W'({IDX_W'(cur_addr), col_q, row_q, cell_q});
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

  // Cursor column never passes the line-full mark
  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    col_q <= COLS_C)
    else $error("cursor column past row end");

  // A result appears only after the sequencer finished a word
  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(state_q == ST_DONE))
    else $error("result without finished word");

  // Store writes stay inside the screen
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr <= LAST_CELL))
    else $error("screen write out of range");

  // Scroll copy reads exactly one row plus one below the write slot
  a_scroll_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCROLL && ram_we && ram_re) |->
      (ram_raddr == ram_waddr + COLS_A + ADDR_W'(1)))
    else $error("scroll copy address skew");

endmodule

// File: verif/testbench.sv
// Self-checking stream testbench for the text console writer.
module testbench;
  import tcw_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // The mode code the block leaves unused; it must change nothing.
  localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;
  localparam int unsigned TAB_STOP = 1 << TAB_BITS;
  // Scrolls and clears each sweep the whole store.
  // Capping them keeps the run well inside the time limit.
  localparam int unsigned SWEEP_BUDGET = 200;
  localparam int unsigned PHASES = 6;
  localparam int unsigned WORDS_PER_PHASE = 220;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [CHAR_W-1:0] ch;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } console_cmd_t;

  typedef struct packed {
    logic [CELL_W-1:0] rd_cell;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [IDX_W-1:0]  lin_index;
  } cursor_report_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic [MODE_W-1:0]     s_axis_tuser = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  cfg_we_i = 1'b0;
  logic [ATTR_W-1:0]     cfg_wdata_i = '0;

  text_console_writer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------
  // Console shadow: screen, cursor and attribute as the block should hold
  // them. Updated once per accepted command word.
  // ---------------------------------------------------------------------
  logic [CELL_W-1:0] screen_shadow [CELL_COUNT];
  logic [ROW_W-1:0]  cur_row;
  logic [COL_W-1:0]  cur_col;
  logic [ATTR_W-1:0] attr_shadow;

  // Clear and reset both leave the fixed blank, never the current attribute.
  function automatic void blank_screen();
    for (int i = 0; i < CELL_COUNT; i++) screen_shadow[i] = BLANK_CELL;
    cur_row = '0;
    cur_col = '0;
  endfunction

  // Move to the start of the next row; on the last row scroll up and
  // refill the bottom row with spaces in the current attribute.
  function automatic void line_feed();
    if (int'(cur_row) < ROWS - 1) begin
      cur_row = cur_row + 1'b1;
    end else begin
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen_shadow[i] = screen_shadow[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen_shadow[i] = {attr_shadow, CH_SPACE};
    end
    cur_col = '0;
  endfunction

  function automatic cursor_report_t console_apply(console_cmd_t c);
    cursor_report_t r;
    int unsigned spaces;
    int unsigned lin;
    r.rd_cell = '0;
    case (c.mode)
      MODE_PUT: begin
        case (c.ch)
          CH_NUL: ;
          CH_LF: line_feed();
          CH_CR: cur_col = '0;
          CH_TAB: begin
            if (cur_col >= COLUMNS) line_feed();
            // spaces up to the next stop, but never past the row end
            spaces = TAB_STOP - (cur_col % TAB_STOP);
            while (spaces != 0 && cur_col < COLUMNS) begin
              screen_shadow[cur_row * COLUMNS + cur_col] = {attr_shadow, CH_SPACE};
              cur_col = cur_col + 1'b1;
              spaces--;
            end
          end
          default: begin
            // a full line wraps before the byte lands
            if (cur_col >= COLUMNS) line_feed();
            screen_shadow[cur_row * COLUMNS + cur_col] = {attr_shadow, c.ch};
            cur_col = cur_col + 1'b1;
          end
        endcase
      end
      MODE_READ: begin
        if (c.row < ROWS && c.col < COLUMNS) r.rd_cell = screen_shadow[c.row * COLUMNS + c.col];
      end
      MODE_CLEAR: blank_screen();
      default: ;
    endcase
    lin = cur_row * COLUMNS + cur_col;
    r.row = cur_row;
    r.col = cur_col;
    r.lin_index = lin[IDX_W-1:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Bookkeeping shared by the generator, driver and monitor
  // ---------------------------------------------------------------------
  console_cmd_t   pending_cmds[$];
  cursor_report_t expected_reports[$];
  int unsigned    queued_total = 0;
  int unsigned    accepted_total = 0;
  int unsigned    counted_words = 0;   // words that do something
  int unsigned    sweeps_left = SWEEP_BUDGET;
  int unsigned    fail_count = 0;
  bit             in_fire = 1'b0;
  bit             out_fire = 1'b0;
  int unsigned    send_gap = 0;
  int unsigned    send_calm = 0;
  int unsigned    take_stall = 0;
  int unsigned    take_calm = 0;

  // Mostly short gaps, a few long ones, and now and then a run with none.
  function automatic int unsigned idle_len(inout int unsigned calm);
    int unsigned roll;
    if (calm != 0) begin
      calm--;
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 3) begin
      calm = $urandom_range(20, 80);
      return 0;
    end
    if (roll < 45) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Driver: presents words at the falling edge, holds each until taken,
  // then waits out a random gap before the next.
  // ---------------------------------------------------------------------
  always @(negedge clk_i) begin
    console_cmd_t next_cmd;
    if (!s_axis_tvalid || in_fire) begin
      if (send_gap != 0) begin
        s_axis_tvalid <= 1'b0;
        send_gap--;
      end else if (pending_cmds.size() != 0) begin
        next_cmd = pending_cmds.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= next_cmd.mode;
        // tdata: char_code, read_row, read_col from bit 0 up, zero pad
        s_axis_tdata  <= {{(IN_DATA_W - IN_BITS){1'b0}}, next_cmd.col, next_cmd.row, next_cmd.ch};
        send_gap = idle_len(send_calm);
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Receiver back-pressure: a random stall after each result word.
  always @(negedge clk_i) begin
    if (out_fire) take_stall = idle_len(take_calm);
    if (take_stall != 0) begin
      m_axis_tready <= 1'b0;
      take_stall--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // ---------------------------------------------------------------------
  // Monitor: samples both channels at the rising edge. The result check
  // runs before the new command is predicted, since one word is in work
  // at a time and a result never belongs to a word taken at the same edge.
  // ---------------------------------------------------------------------
  always @(posedge clk_i) begin
    cursor_report_t want;
    console_cmd_t   seen;
    in_fire  = rst_ni && s_axis_tvalid && s_axis_tready;
    out_fire = rst_ni && m_axis_tvalid && m_axis_tready;
    if (out_fire) begin
      if (expected_reports.size() == 0) begin
        $display("%0t ns: result word with nothing expected, tdata 0x%0h", $time, m_axis_tdata);
        fail_count++;
      end else begin
        want = expected_reports.pop_front();
        check_field("read_cell", want.rd_cell, m_axis_tdata[CELL_W-1:0]);
        check_field("cursor_row", want.row, m_axis_tdata[CELL_W +: ROW_W]);
        check_field("cursor_col", want.col, m_axis_tdata[CELL_W + ROW_W +: COL_W]);
        check_field("cursor_index", want.lin_index, m_axis_tdata[CELL_W + ROW_W + COL_W +: IDX_W]);
      end
    end
    if (in_fire) begin
      seen.mode = s_axis_tuser;
      seen.ch   = s_axis_tdata[CHAR_W-1:0];
      seen.row  = s_axis_tdata[CHAR_W +: ROW_W];
      seen.col  = s_axis_tdata[CHAR_W + ROW_W +: COL_W];
      expected_reports.push_back(console_apply(seen));
      accepted_total++;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  task automatic queue_cmd(input logic [MODE_W-1:0] mode, input logic [CHAR_W-1:0] ch,
                           input logic [ROW_W-1:0] row, input logic [COL_W-1:0] col);
    console_cmd_t c;
    c.mode = mode;
    c.ch   = ch;
    c.row  = row;
    c.col  = col;
    pending_cmds.push_back(c);
    queued_total++;
    // NUL bytes and the spare mode are ignored by the block
    if (!(mode == MODE_SPARE || (mode == MODE_PUT && ch == CH_NUL))) counted_words++;
  endtask

  // Put with random don't-care read coordinates.
  task automatic queue_put(input logic [CHAR_W-1:0] ch);
    queue_cmd(MODE_PUT, ch, ROW_W'($urandom_range(0, 31)), COL_W'($urandom_range(0, 127)));
  endtask

  // Reads lean toward the bottom rows, where scrolled text collects;
  // a few land outside the screen.
  task automatic queue_random_read();
    int unsigned roll;
    int unsigned row;
    int unsigned col;
    roll = $urandom_range(0, 99);
    if (roll < 45) row = $urandom_range(ROWS - 7, ROWS - 1);
    else if (roll < 90) row = $urandom_range(0, ROWS - 1);
    else row = $urandom_range(0, 31);
    col = ($urandom_range(0, 9) != 0) ? $urandom_range(0, COLUMNS - 1) : $urandom_range(0, 127);
    queue_cmd(MODE_READ, CHAR_W'($urandom_range(0, 255)), ROW_W'(row), COL_W'(col));
  endtask

  function automatic logic [CHAR_W-1:0] printable_byte();
    logic [CHAR_W-1:0] ch;
    do ch = CHAR_W'($urandom_range(1, 255));
    while (ch == CH_TAB || ch == CH_LF || ch == CH_CR);
    return ch;
  endfunction

  // One chunk of random traffic: mostly text lines ended by a newline,
  // some read bursts, a little noise, and the odd clear.
  task automatic queue_segment();
    int unsigned kind;
    int unsigned len;
    int unsigned roll;
    kind = $urandom_range(0, 99);
    if (kind < 68) begin
      // long lines wrap and push tabs against the row end
      len = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 24) : $urandom_range(70, 100);
      repeat (len) begin
        roll = $urandom_range(0, 99);
        if (roll < 80) queue_put(printable_byte());
        else if (roll < 88) queue_put(CH_TAB);
        else if (roll < 91) queue_put(CH_CR);
        else if (roll < 94) queue_put(CH_NUL);
        else queue_random_read();
      end
      if (sweeps_left != 0 && $urandom_range(0, 9) != 0) begin
        sweeps_left--;
        queue_put(CH_LF);
      end else begin
        queue_put(CH_CR);
      end
    end else if (kind < 90) begin
      repeat ($urandom_range(1, 6)) queue_random_read();
    end else if (kind < 95) begin
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 1) != 0) queue_cmd(MODE_SPARE, CHAR_W'($urandom_range(0, 255)),
                                                 ROW_W'($urandom_range(0, 31)),
                                                 COL_W'($urandom_range(0, 127)));
        else queue_put(CH_NUL);
      end
    end else if (sweeps_left != 0) begin
      sweeps_left--;
      queue_cmd(MODE_CLEAR, CHAR_W'($urandom_range(0, 255)), ROW_W'($urandom_range(0, 31)),
                COL_W'($urandom_range(0, 127)));
    end
  endtask

  // Every word yields one result, so an empty expectation queue with all
  // words taken means the block is idle.
  task automatic wait_drained();
    while (accepted_total != queued_total || expected_reports.size() != 0) @(negedge clk_i);
  endtask

  task automatic set_attribute(input logic [ATTR_W-1:0] value);
    wait_drained();
    repeat (8) @(negedge clk_i);
    cfg_wdata_i <= value;
    cfg_we_i    <= 1'b1;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    attr_shadow = value;
  endtask

  initial begin
    logic [ATTR_W-1:0] attr_plan [4];
    attr_plan = '{8'h00, 8'hFF, 8'h5A, 8'hA5};
    blank_screen();
    attr_shadow = ATTR_RESET;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed pass, reset attribute in force.
    // Fresh store reads blank at both corners; reads off the screen give 0.
    queue_cmd(MODE_READ, 8'h00, 5'd0, 7'd0);
    queue_cmd(MODE_READ, 8'hFF, 5'd24, 7'd79);
    queue_cmd(MODE_READ, 8'h00, 5'd31, 7'd127);
    queue_cmd(MODE_READ, 8'h00, 5'd25, 7'd0);
    queue_cmd(MODE_READ, 8'h00, 5'd0, 7'd80);
    // byte extremes, then an ignored zero byte
    queue_put(8'h41);
    queue_put(8'hFF);
    queue_put(8'h01);
    queue_put(CH_NUL);
    queue_put(8'h80);
    queue_cmd(MODE_READ, 8'h00, 5'd0, 7'd1);
    // tab from a stop writes four spaces, from mid-stop fewer
    queue_put(CH_TAB);
    queue_put(8'h78);
    queue_put(CH_TAB);
    queue_cmd(MODE_READ, 8'h00, 5'd0, 7'd9);
    queue_cmd(MODE_READ, 8'h00, 5'd0, 7'd11);
    queue_put(CH_CR);
    queue_put(CH_TAB);
    queue_put(CH_LF);
    queue_cmd(MODE_SPARE, 8'hFF, 5'd31, 7'd127);
    queue_cmd(MODE_CLEAR, 8'h00, 5'd0, 7'd0);
    queue_cmd(MODE_READ, 8'h00, 5'd0, 7'd0);
    queue_put(8'h7E);

    // Random phases, each under its own attribute; extremes come first.
    for (int p = 0; p < PHASES; p++) begin
      set_attribute((p < 4) ? attr_plan[p] : ATTR_W'($urandom_range(0, 255)));
      counted_words = 0;
      while (counted_words < WORDS_PER_PHASE) queue_segment();
    end

    wait_drained();
    repeat (20) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Worst case is a few hundred store sweeps plus every gap and stall at
  // its longest; this allows several times that.
  initial begin
    #(30_000_000);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
sv/tcw_pkg.sv
sv/tcw_ram.sv
sv/text_console_writer.sv
verif/testbench.sv
